// ===== rtl/lsd_pkg.sv =====
// Package for the decimal radix sorter: sizes, constants and shared types.
// No dependencies.
package lsd_pkg;

  localparam int unsigned MaxItemsDefault = 64;
  localparam int unsigned ValueW = 31;
  localparam int unsigned Radix = 10;
  localparam int unsigned DigitW = 4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_item;    // write the input item at the fill level
    logic drop_item;     // buffer full: set the dropped flag
    logic clear_set;     // end of set: reset fill level and dropped flag
    logic max_start;     // restart the maximum search
    logic max_step;      // fold item_store read data into the maximum
    logic dig_start;     // begin digit counting of the maximum
    logic dig_step;      // raise the digit threshold tenfold
    logic pass_start;    // clear digit counts and the prefix index
    logic count_step;    // count the digit of the read data
    logic prefix_step;   // one prefix-sum step
    logic scatter_step;  // scatter the read data
    logic copy_step;     // copy read scatter data back
    logic idx_up;        // index += 1
    logic idx_down;      // index -= 1
    logic idx_top;       // index = fill level - 1
    logic idx_zero;      // index = 0
  } lsd_cmd_t;

  typedef struct packed {
    logic full;          // fill level at capacity
    logic idx_last;      // index is at fill level - 1
    logic idx_first;     // index is zero
    logic dig_done;      // maximum has no digits left
    logic prefix_done;   // prefix sum finished
    logic more_digits;   // another pass is needed
  } lsd_stat_t;

endpackage

// ===== rtl/lsd_ram.sv =====
// Generic single-port-write, one-read RAM with registered read data.
// No dependencies.
module lsd_ram #(
  parameter int unsigned Width = 31,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/lsd_datapath.sv =====
// Datapath of the decimal radix sorter: stores, counters, digit extraction.
// Depends on lsd_pkg, lsd_ram and lsd_scdiv.
module lsd_datapath #(
  parameter int unsigned MaxItems = lsd_pkg::MaxItemsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lsd_pkg::lsd_cmd_t          cmd,
  output lsd_pkg::lsd_stat_t         stat,
  input  logic [lsd_pkg::ValueW-1:0] value,
  output logic [lsd_pkg::ValueW-1:0] value_res,
  output logic                       overflow
);
  import lsd_pkg::*;

  localparam int unsigned AW = (MaxItems > 1) ? $clog2(MaxItems) : 1;
  localparam int unsigned CW = $clog2(MaxItems + 1);
  localparam int unsigned RD = (MaxItems > 1) ? MaxItems : 2;
  localparam int unsigned EW = 2 * ValueW;
  localparam int unsigned LW = ValueW + 3;

  logic [CW-1:0] fill_level;
  logic          dropped_flag;
  logic [AW-1:0] idx;
  logic [EW-1:0] item_rdata, scat_rdata;
  logic [ValueW-1:0] item_value, item_key;
  logic [ValueW-1:0] mx;
  logic [LW-1:0] limit;
  logic [3:0]    digits, pass_cnt;
  logic [ValueW-1:0] key_rest;
  logic [CW-1:0] counts [Radix];
  logic [3:0]    pfx;
  logic          item_we, scat_we;
  logic [AW-1:0] item_waddr, scat_waddr;
  logic [EW-1:0] item_wdata, scat_wdata;
  logic [DigitW-1:0] dgt;
  logic [CW-1:0] dec_cnt;

  // Each entry holds {key, value}. The key starts as the value and is divided
  // by ten as the entry is scattered, so its low digit is always the digit of
  // the current pass.
  assign item_key   = item_rdata[EW-1:ValueW];
  assign item_value = item_rdata[ValueW-1:0];

  lsd_scdiv #(.W(ValueW)) u_split (
    .clk, .num(item_key), .quot(key_rest), .rem(dgt));

  assign item_we    = cmd.store_item | cmd.copy_step;
  assign item_waddr = cmd.store_item ? fill_level[AW-1:0] : idx;
  assign item_wdata = cmd.store_item ? {value, value} : scat_rdata;
  assign scat_we    = cmd.scatter_step;
  assign dec_cnt    = counts[dgt] - CW'(1);
  assign scat_waddr = dec_cnt[AW-1:0];
  assign scat_wdata = {key_rest, item_value};

  lsd_ram #(.Width(EW), .Depth(RD)) u_items (
    .clk, .we(item_we), .waddr(item_waddr), .wdata(item_wdata),
    .raddr(idx), .rdata(item_rdata));
  lsd_ram #(.Width(EW), .Depth(RD)) u_scatter (
    .clk, .we(scat_we), .waddr(scat_waddr), .wdata(scat_wdata),
    .raddr(idx), .rdata(scat_rdata));

  assign stat.full        = (fill_level == CW'(MaxItems));
  assign stat.idx_last    = (CW'(idx) == CW'(fill_level - CW'(1)));
  assign stat.idx_first   = (idx == '0);
  assign stat.dig_done    = (LW'(mx) < limit);
  assign stat.prefix_done = (pfx == 4'(Radix - 1));
  assign stat.more_digits = (pass_cnt != digits);
  assign value_res        = item_value;
  assign overflow         = dropped_flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_level   <= '0;
      dropped_flag <= 1'b0;
    end else begin
      if (cmd.store_item) fill_level <= fill_level + CW'(1);
      if (cmd.drop_item) dropped_flag <= 1'b1;
      if (cmd.clear_set) begin
        fill_level   <= '0;
        dropped_flag <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_zero) idx <= '0;
    else if (cmd.idx_top) idx <= AW'(fill_level - CW'(1));
    else if (cmd.idx_up) idx <= idx + AW'(1);
    else if (cmd.idx_down) idx <= idx - AW'(1);

    if (cmd.max_start) mx <= '0;
    else if (cmd.max_step && item_value > mx) mx <= item_value;

    // The digit count grows until the threshold passes the maximum.
    if (cmd.dig_start) begin
      limit    <= LW'(Radix);
      digits   <= 4'd1;
      pass_cnt <= '0;
    end else if (cmd.dig_step) begin
      limit  <= (limit << 3) + (limit << 1);
      digits <= digits + 4'd1;
    end

    if (cmd.pass_start) begin
      for (int k = 0; k < Radix; k++) counts[k] <= '0;
      pfx <= '0;
      pass_cnt <= pass_cnt + 4'd1;
    end else if (cmd.count_step) begin
      counts[dgt] <= counts[dgt] + CW'(1);
    end else if (cmd.prefix_step) begin
      counts[pfx + 4'd1] <= counts[pfx + 4'd1] + counts[pfx];
      pfx <= pfx + 4'd1;
    end else if (cmd.scatter_step) begin
      counts[dgt] <= dec_cnt;
    end
  end
endmodule

// ===== rtl/lsd_div10.sv =====
// Divide-by-ten by reciprocal multiply with one correction step.
// Depends on nothing beyond its own parameter.
module lsd_div10 #(
  parameter int unsigned W = 31
) (
  input  logic [W-1:0] num,
  output logic [W-1:0] quot,
  output logic [3:0]   rem
);
  logic [W+31:0]  prod;
  logic [W-1:0]   q0;
  logic [W+3:0]   r0;

  // 0xCCCCCCCD / 2^35 approximates one tenth; one correction makes it exact.
  assign prod = (W+32)'(num) * (W+32)'(32'hCCCCCCCD);
  assign q0   = W'(prod >> 35);
  assign r0   = (W+4)'(num) - (W+4)'((q0 << 3) + (q0 << 1));
  always_comb begin
    if (r0 >= (W+4)'(10)) begin
      quot = q0 + W'(1);
      rem  = 4'(r0 - (W+4)'(10));
    end else begin
      quot = q0;
      rem  = r0[3:0];
    end
  end
endmodule

// ===== rtl/lsd_scdiv.sv =====
// Registered split of a key into its low decimal digit and the key over ten.
// Depends on lsd_div10.
module lsd_scdiv #(
  parameter int unsigned W = 31
) (
  input  logic         clk,
  input  logic [W-1:0] num,
  output logic [W-1:0] quot,
  output logic [3:0]   rem
);
  logic [W-1:0] quot_next;
  logic [3:0]   rem_next;

  lsd_div10 #(.W(W)) u_div10 (.num(num), .quot(quot_next), .rem(rem_next));

  always_ff @(posedge clk) begin
    quot <= quot_next;
    rem  <= rem_next;
  end
endmodule

// ===== rtl/lsd_ctrl.sv =====
// Controller state machine of the decimal radix sorter.
// Depends on lsd_pkg.
module lsd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               last,
  output logic               busy,
  output logic               strobe,
  output logic               last_res,
  input  lsd_pkg::lsd_stat_t stat,
  output lsd_pkg::lsd_cmd_t  cmd
);
  import lsd_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_MAXRD = 13'b0000000000010,
    S_MAX   = 13'b0000000000100,
    S_DIG   = 13'b0000000001000,
    S_PASS  = 13'b0000000010000,
    S_CNTRD = 13'b0000000100000,
    S_CNT   = 13'b0000001000000,
    S_PFX   = 13'b0000010000000,
    S_SCRD  = 13'b0000100000000,
    S_SC    = 13'b0001000000000,
    S_CPRD  = 13'b0010000000000,
    S_CP    = 13'b0100000000000,
    S_EMIT  = 13'b1000000000000
  } state_t;

  state_t state, state_next;
  logic   wait_q, wait_q_next, fin, fin_next;

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      wait_q <= 1'b0;
      fin    <= 1'b0;
    end else begin
      state  <= state_next;
      wait_q <= wait_q_next;
      fin    <= fin_next;
    end
  end

  // The count and scatter read stages issue an address, wait for RAM data,
  // then wait on the divider register (wait_q) before the digit is valid.
  always_comb begin
    state_next  = state;
    wait_q_next = 1'b0;
    fin_next    = fin;
    cmd         = '0;
    strobe      = 1'b0;
    last_res    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (stat.full) cmd.drop_item = 1'b1;
          else cmd.store_item = 1'b1;
          if (last) begin
            state_next = S_MAXRD;
            cmd.idx_zero = 1'b1;
            cmd.max_start = 1'b1;
          end
        end
      end
      S_MAXRD: begin
        state_next = S_MAX;
      end
      S_MAX: begin
        cmd.max_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_DIG;
        end else begin
          cmd.idx_up = 1'b1;
          state_next = S_MAXRD;
        end
      end
      S_DIG: begin
        if (!wait_q) begin
          cmd.dig_start = 1'b1;
          wait_q_next = 1'b1;
        end else if (stat.dig_done) begin
          state_next = S_PASS;
        end else begin
          cmd.dig_step = 1'b1;
          wait_q_next = 1'b1;
        end
      end
      S_PASS: begin
        cmd.pass_start = 1'b1;
        cmd.idx_zero = 1'b1;
        state_next = S_CNTRD;
      end
      S_CNTRD: begin
        wait_q_next = !wait_q;
        if (wait_q) state_next = S_CNT;
      end
      S_CNT: begin
        cmd.count_step = 1'b1;
        if (stat.idx_last) begin
          state_next = S_PFX;
        end else begin
          cmd.idx_up = 1'b1;
          state_next = S_CNTRD;
        end
      end
      S_PFX: begin
        if (stat.prefix_done) begin
          cmd.idx_top = 1'b1;
          state_next = S_SCRD;
        end else begin
          cmd.prefix_step = 1'b1;
        end
      end
      S_SCRD: begin
        wait_q_next = !wait_q;
        if (wait_q) state_next = S_SC;
      end
      S_SC: begin
        cmd.scatter_step = 1'b1;
        if (stat.idx_first) begin
          cmd.idx_zero = 1'b1;
          state_next = S_CPRD;
        end else begin
          cmd.idx_down = 1'b1;
          state_next = S_SCRD;
        end
      end
      S_CPRD: begin
        state_next = S_CP;
      end
      S_CP: begin
        cmd.copy_step = 1'b1;
        if (stat.idx_last) begin
          cmd.idx_zero = 1'b1;
          if (stat.more_digits) begin
            state_next = S_PASS;
          end else begin
            fin_next = 1'b0;
            state_next = S_EMIT;
          end
        end else begin
          cmd.idx_up = 1'b1;
          state_next = S_CPRD;
        end
      end
      S_EMIT: begin
        // fin toggles between a RAM read and the result strobe.
        fin_next = !fin;
        if (fin) begin
          strobe = 1'b1;
          if (stat.idx_last) begin
            last_res = 1'b1;
            cmd.clear_set = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.idx_up = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/lsd_decimal_radix_sorter_core.sv =====
// Top level of the decimal radix sorter: controller plus datapath.
// Depends on lsd_pkg, lsd_ctrl and lsd_datapath.
//
// Channel   Ports                                 Transaction
// input     start, busy, value, last              start high while busy low
// result    strobe, value_res, last_res, overflow one cycle per strobe
//
// Loading accepts one item per cycle while busy is low. The closing item
// starts the sort: a search for the maximum, a count of its decimal digits,
// then per digit a pass that clears the counts, counts the digits, forms
// prefix sums, scatters and copies back, then the emit of the results.
// Synchronous reset clears the controller, the fill level and the overflow
// flag; the result side has no stall, so busy covers the whole sort and emit.
module lsd_decimal_radix_sorter_core #(
  parameter int unsigned MaxItems = lsd_pkg::MaxItemsDefault
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [lsd_pkg::ValueW-1:0] value,
  input  logic                       last,
  output logic                       strobe,
  output logic [lsd_pkg::ValueW-1:0] value_res,
  output logic                       last_res,
  output logic                       overflow
);
  import lsd_pkg::*;

  lsd_cmd_t  cmd;
  lsd_stat_t stat;

  lsd_ctrl u_ctrl (
    .clk, .rst, .start, .last, .busy, .strobe, .last_res, .stat, .cmd);

  lsd_datapath #(.MaxItems(MaxItems)) u_dp (
    .clk, .rst, .cmd, .stat, .value, .value_res, .overflow);
endmodule
